[src/cplv_pkg.sv]
// Shared widths, lane codes and types for the camera pose look-vector pipeline.
package cplv_pkg;

    localparam int POS_W   = 32;   // Q15.16 positions
    localparam int QUAT_W  = 16;   // Q3.12 quaternion parts
    localparam int UP_W    = 16;   // Q1.14 up vector
    localparam int PROD_W  = 32;   // one 16x16 signed product
    localparam int NUM_W   = 34;   // signed numerator of one matrix entry
    localparam int MAG_W   = 33;   // magnitude of a numerator, also the norm n
    localparam int DEN_W   = 34;   // divisor 2n
    localparam int DVD_W   = 50;   // dividend 2*mag*scale + n
    localparam int QB      = 17;   // quotient bits, enough for 65536
    localparam int LANES   = 6;

    localparam int UP_SHIFT  = 14; // 16384 = 1.0 for up
    localparam int POS_SHIFT = 16; // 65536 = 1.0 for positions
    localparam logic [QB-1:0] UP_ONE_Q = QB'(17'd16384);

    // lane order: up x, up y, up z, column3 x, column3 y, column3 z
    typedef enum logic [2:0] {
        L_UPX  = 3'd0,
        L_UPY  = 3'd1,
        L_UPZ  = 3'd2,
        L_COLX = 3'd3,
        L_COLY = 3'd4,
        L_COLZ = 3'd5
    } t_lane;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_eye;

endpackage

[src/camera_pose_look_vectors.sv]
// Camera pose look-vector pipeline: quaternion to up vector and look-at center.
//
// Each word carries an eye position (Q15.16) and a quaternion (Q3.12) that
// need not be unit length. The block forms the rotation matrix of the
// normalized quaternion without a square root: every matrix entry is a
// quadratic form of the raw parts divided by n = x*x+y*y+z*z+w*w. It returns
// the second column as the up vector (Q1.14, 16384 = 1.0) and the eye minus
// the third column as the look-at center (Q15.16, saturating). Quotients
// round to nearest with ties away from zero. An all-zero quaternion raises
// o_zero_quat, with up = 0 and center = eye. The pipeline takes one word per
// cycle while the output is not stalled: one stage of ten 16x16 multipliers,
// one stage of sums, one stage that builds the dividends, seventeen stages
// of a restoring divider (one quotient bit per stage, six lanes side by
// side) and one output stage with sign, clamp and saturation. A stall at
// the output freezes every stage at once, so nothing is lost or repeated.
module camera_pose_look_vectors
    import cplv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [POS_W-1:0]  i_eye_x_pos,
    input  logic signed [POS_W-1:0]  i_eye_y_pos,
    input  logic signed [POS_W-1:0]  i_eye_z_pos,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_look_x,
    output logic signed [POS_W-1:0]  o_look_y,
    output logic signed [POS_W-1:0]  o_look_z,
    output logic signed [UP_W-1:0]   o_upward_x,
    output logic signed [UP_W-1:0]   o_upward_y,
    output logic signed [UP_W-1:0]   o_upward_z,
    output logic                     o_zero_quat
);

    // advance every stage together unless the output word is stuck
    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- stage A: products ----------------
    logic                     r_a_vld;
    t_eye                     r_a_eye;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_zz, r_ww;
    logic signed [PROD_W-1:0] r_xy, r_wz, r_yz, r_wx, r_xz, r_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_eye <= '{x: i_eye_x_pos, y: i_eye_y_pos, z: i_eye_z_pos};
            r_xx    <= i_quat_x * i_quat_x;
            r_yy    <= i_quat_y * i_quat_y;
            r_zz    <= i_quat_z * i_quat_z;
            r_ww    <= i_quat_w * i_quat_w;
            r_xy    <= i_quat_x * i_quat_y;
            r_wz    <= i_quat_w * i_quat_z;
            r_yz    <= i_quat_y * i_quat_z;
            r_wx    <= i_quat_w * i_quat_x;
            r_xz    <= i_quat_x * i_quat_z;
            r_wy    <= i_quat_w * i_quat_y;
        end
    end

    // ---------------- stage B: norm and numerators ----------------
    logic signed [NUM_W-1:0] w_num [LANES];
    logic signed [NUM_W-1:0] w_nsum;

    always_comb begin
        w_nsum          = NUM_W'(r_xx) + NUM_W'(r_yy) + NUM_W'(r_zz) + NUM_W'(r_ww);
        w_num[L_UPX]    = (NUM_W'(r_xy) - NUM_W'(r_wz)) <<< 1;
        w_num[L_UPY]    = NUM_W'(r_ww) + NUM_W'(r_yy) - NUM_W'(r_xx) - NUM_W'(r_zz);
        w_num[L_UPZ]    = (NUM_W'(r_yz) + NUM_W'(r_wx)) <<< 1;
        w_num[L_COLX]   = (NUM_W'(r_xz) + NUM_W'(r_wy)) <<< 1;
        w_num[L_COLY]   = (NUM_W'(r_yz) - NUM_W'(r_wx)) <<< 1;
        w_num[L_COLZ]   = NUM_W'(r_ww) + NUM_W'(r_zz) - NUM_W'(r_xx) - NUM_W'(r_yy);
    end

    logic             r_b_vld;
    t_eye             r_b_eye;
    logic             r_b_zf;
    logic [MAG_W-1:0] r_b_n;
    logic [MAG_W-1:0] r_b_mag [LANES];
    logic             r_b_neg [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_eye <= r_a_eye;
            r_b_n   <= MAG_W'(w_nsum);
            r_b_zf  <= (w_nsum == '0);
            for (int l = 0; l < LANES; l++) begin
                r_b_neg[l] <= w_num[l][NUM_W-1];
                r_b_mag[l] <= w_num[l][NUM_W-1] ? MAG_W'(-w_num[l]) : MAG_W'(w_num[l]);
            end
        end
    end

    // ---------------- divider: index 0 holds the dividends ----------------
    logic             r_dv_vld [QB+1];
    t_eye             r_dv_eye [QB+1];
    logic             r_dv_zf  [QB+1];
    logic [DEN_W-1:0] r_dv_den [QB+1];
    logic [DVD_W-1:0] r_dv_rem [QB+1][LANES];
    logic [QB-1:0]    r_dv_quo [QB+1][LANES];
    logic             r_dv_neg [QB+1][LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_vld[0] <= r_b_vld;
            for (int k = 0; k < QB; k++) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end
    end

    // build 2*mag*scale + n over divisor 2n
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_eye[0] <= r_b_eye;
            r_dv_zf[0]  <= r_b_zf;
            r_dv_den[0] <= {r_b_n, 1'b0};
            for (int l = 0; l < LANES; l++) begin
                r_dv_neg[0][l] <= r_b_neg[l];
                r_dv_quo[0][l] <= '0;
                if (l < int'(L_COLX)) begin
                    r_dv_rem[0][l] <= (DVD_W'(r_b_mag[l]) << (UP_SHIFT + 1))
                                      + DVD_W'(r_b_n);
                end else begin
                    r_dv_rem[0][l] <= (DVD_W'(r_b_mag[l]) << (POS_SHIFT + 1))
                                      + DVD_W'(r_b_n);
                end
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BIT = QB - 1 - k;
        logic [DVD_W-1:0] w_sub;
        assign w_sub = DVD_W'(r_dv_den[k]) << BIT;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_eye[k+1] <= r_dv_eye[k];
                r_dv_zf[k+1]  <= r_dv_zf[k];
                r_dv_den[k+1] <= r_dv_den[k];
                for (int l = 0; l < LANES; l++) begin
                    r_dv_neg[k+1][l] <= r_dv_neg[k][l];
                    if (r_dv_rem[k][l] >= w_sub) begin
                        r_dv_rem[k+1][l] <= r_dv_rem[k][l] - w_sub;
                        r_dv_quo[k+1][l] <= {r_dv_quo[k][l][QB-2:0], 1'b1};
                    end else begin
                        r_dv_rem[k+1][l] <= r_dv_rem[k][l];
                        r_dv_quo[k+1][l] <= {r_dv_quo[k][l][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- output stage: sign, clamp, saturate ----------------
    logic signed [UP_W-1:0]  w_up  [3];
    logic signed [POS_W-1:0] w_lk  [3];
    logic signed [POS_W-1:0] w_eye [3];

    assign w_eye[0] = r_dv_eye[QB].x;
    assign w_eye[1] = r_dv_eye[QB].y;
    assign w_eye[2] = r_dv_eye[QB].z;

    always_comb begin
        logic [QB-1:0]          v_q;
        logic signed [QB:0]     v_c;
        logic signed [POS_W+1:0] v_d;
        for (int a = 0; a < 3; a++) begin
            v_q = r_dv_quo[QB][a];
            if (v_q > UP_ONE_Q) begin
                v_q = UP_ONE_Q;
            end
            w_up[a] = r_dv_neg[QB][a] ? -UP_W'(v_q) : UP_W'(v_q);

            v_c = r_dv_neg[QB][a+3] ? -$signed({1'b0, r_dv_quo[QB][a+3]})
                                    :  $signed({1'b0, r_dv_quo[QB][a+3]});
            v_d = (POS_W+2)'(w_eye[a]) - (POS_W+2)'(v_c);
            if (r_dv_zf[QB]) begin
                w_up[a] = '0;
                w_lk[a] = w_eye[a];
            end else if (v_d > (POS_W+2)'(32'sh7fff_ffff)) begin
                w_lk[a] = {1'b0, {(POS_W-1){1'b1}}};
            end else if (v_d < -(POS_W+2)'(34'sh0_8000_0000)) begin
                w_lk[a] = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                w_lk[a] = POS_W'(v_d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_dv_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_look_x    <= w_lk[0];
            o_look_y    <= w_lk[1];
            o_look_z    <= w_lk[2];
            o_upward_x  <= w_up[0];
            o_upward_y  <= w_up[1];
            o_upward_z  <= w_up[2];
            o_zero_quat <= r_dv_zf[QB];
        end
    end

    // ---------------- checks ----------------
    a_zero_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_quat |->
            o_upward_x == '0 && o_upward_y == '0 && o_upward_z == '0)
        else $error("zero quaternion with nonzero up");

    a_up_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_upward_x <= 16'sd16384 && o_upward_x >= -16'sd16384 &&
            o_upward_y <= 16'sd16384 && o_upward_y >= -16'sd16384 &&
            o_upward_z <= 16'sd16384 && o_upward_z >= -16'sd16384)
        else $error("up vector out of range");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_dv_vld[QB]) && $stable(r_a_vld) && $stable(r_b_vld))
        else $error("pipeline moved during stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule

[bench/camera_pose_look_vectors_tb.sv]
// Testbench for the camera pose look-vector pipeline: random and directed poses, self-checking.
`timescale 1ns / 100ps

module camera_pose_look_vectors_tb;
    import cplv_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]  ex, ey, ez;
        logic signed [QUAT_W-1:0] qx, qy, qz, qw;
    } t_pose;

    typedef struct {
        logic signed [POS_W-1:0] lx, ly, lz;
        logic signed [UP_W-1:0]  ux, uy, uz;
        logic                    zq;
    } t_look;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [POS_W-1:0]  i_eye_x_pos = '0, i_eye_y_pos = '0, i_eye_z_pos = '0;
    logic signed [QUAT_W-1:0] i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_look_x, o_look_y, o_look_z;
    logic signed [UP_W-1:0]  o_upward_x, o_upward_y, o_upward_z;
    logic o_zero_quat;

    t_pose pending_poses[$];
    t_look expected_looks[$];
    int    fail_count = 0;
    bit    stim_done = 1'b0;
    bit    calm = 1'b0;        // set for the last part of the run: no idling
    bit    hold_off = 1'b0;    // long receiver stall to fill the pipeline
    int    send_gap = 0;
    int    recv_gap = 0;

    always #10 i_clk = ~i_clk;

    camera_pose_look_vectors i_dut (.*);

    // Round num*scale/n to nearest, ties away from zero; n > 0.
    function automatic longint scaled_quotient(longint num, longint scale, longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag * scale + n) / (2 * n);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Predict the look-at center and up vector of one pose.
    function automatic t_look look_of_pose(t_pose p);
        t_look r;
        longint x, y, z, w, n, cx, cy, cz;
        x = p.qx; y = p.qy; z = p.qz; w = p.qw;
        n = x*x + y*y + z*z + w*w;
        r.lx = p.ex; r.ly = p.ey; r.lz = p.ez;
        r.ux = '0; r.uy = '0; r.uz = '0;
        r.zq = (n == 0);
        if (n != 0) begin
            r.ux = UP_W'(clip(scaled_quotient(2*(x*y - w*z), 16384, n), -16384, 16384));
            r.uy = UP_W'(clip(scaled_quotient(w*w + y*y - x*x - z*z, 16384, n),
                              -16384, 16384));
            r.uz = UP_W'(clip(scaled_quotient(2*(y*z + w*x), 16384, n), -16384, 16384));
            cx = scaled_quotient(2*(x*z + w*y), 65536, n);
            cy = scaled_quotient(2*(y*z - w*x), 65536, n);
            cz = scaled_quotient(w*w + z*z - x*x - y*y, 65536, n);
            r.lx = POS_W'(clip(longint'(p.ex) - cx, -64'sd2147483648, 64'sd2147483647));
            r.ly = POS_W'(clip(longint'(p.ey) - cy, -64'sd2147483648, 64'sd2147483647));
            r.lz = POS_W'(clip(longint'(p.ez) - cz, -64'sd2147483648, 64'sd2147483647));
        end
        return r;
    endfunction

    function automatic logic [QUAT_W-1:0] rand_quat_part();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 8) - 4);
            3: return 16'($urandom_range(0, 8192) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_eye();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000 + $urandom_range(0, 200000);
            1: return 32'h7fff_ffff - $urandom_range(0, 200000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_pose(logic [POS_W-1:0] ex, ey, ez, logic [QUAT_W-1:0] qx, qy, qz, qw);
        t_pose p;
        p.ex = ex; p.ey = ey; p.ez = ez;
        p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
        pending_poses.push_back(p);
    endtask

    // Driver: advance to the next pose on acceptance, idle in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (i_in_valid)
                    expected_looks.push_back(look_of_pose(pending_poses.pop_front()));
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_poses.size() > 0) begin
                    // peek the next pose still waiting in the queue
                    automatic t_pose p = pending_poses[0];
                    i_in_valid  <= 1'b1;
                    i_eye_x_pos <= p.ex; i_eye_y_pos <= p.ey; i_eye_z_pos <= p.ez;
                    i_quat_x <= p.qx; i_quat_y <= p.qy; i_quat_z <= p.qz; i_quat_w <= p.qw;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_looks.size() == 0) begin
                    $error("unexpected output word");
                    fail_count++;
                end else begin
                    automatic t_look e = expected_looks.pop_front();
                    if (o_look_x !== e.lx) begin
                        $error("look_x exp %0d got %0d", e.lx, o_look_x); fail_count++;
                    end
                    if (o_look_y !== e.ly) begin
                        $error("look_y exp %0d got %0d", e.ly, o_look_y); fail_count++;
                    end
                    if (o_look_z !== e.lz) begin
                        $error("look_z exp %0d got %0d", e.lz, o_look_z); fail_count++;
                    end
                    if (o_upward_x !== e.ux) begin
                        $error("upward_x exp %0d got %0d", e.ux, o_upward_x); fail_count++;
                    end
                    if (o_upward_y !== e.uy) begin
                        $error("upward_y exp %0d got %0d", e.uy, o_upward_y); fail_count++;
                    end
                    if (o_upward_z !== e.uz) begin
                        $error("upward_z exp %0d got %0d", e.uz, o_upward_z); fail_count++;
                    end
                    if (o_zero_quat !== e.zq) begin
                        $error("zero_quat exp %0d got %0d", e.zq, o_zero_quat); fail_count++;
                    end
                end
            end
            // receiver idling: a long hold-off wins over random bursts
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 14);
            end
        end
    end

    // Long stall once, counted in its own process, while the sender keeps going.
    initial begin
        repeat (400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (120) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        // directed: extremes, zero quaternion, axis quaternions, saturation
        add_pose(0, 0, 0, 0, 0, 0, 0);
        add_pose(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 0, 0, 0, 0);
        add_pose(0, 0, 0, 0, 0, 0, 16'sd4096);
        add_pose(0, 0, 0, 16'sd4096, 0, 0, 0);
        add_pose(0, 0, 0, 0, 16'sd4096, 0, 0);
        add_pose(0, 0, 0, 0, 0, 16'sd4096, 0);
        add_pose(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_pose(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_pose(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        add_pose(0, 0, 0, 0, 0, 0, 16'sh8000);
        add_pose(0, 0, 0, 0, 0, 0, 1);
        add_pose(0, 0, 0, 1, 0, 0, 0);
        add_pose(0, 0, 0, 1, 1, 1, 1);
        add_pose(0, 0, 0, 16'hffff, 1, 16'hffff, 1);
        // center at or near saturation both ways (column3 = (0,0,+1), (0,0,-1) or (+1,0,0))
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16'sd4096);
        add_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'sd4096, 0, 0, 0);
        add_pose(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 16'sd4096, 0, 0);
        add_pose(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'sd4096, 0, 16'sd4096, 0);
        add_pose(32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa, 3, 16'hfffd, 2, 16'hfffe);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 1730; k++) begin
            if (k == 1500) begin
                wait (pending_poses.size() == 0);
                calm = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
                add_pose(rand_eye(), rand_eye(), rand_eye(), 0, 0, 0, 0);
            else
                add_pose(rand_eye(), rand_eye(), rand_eye(), rand_quat_part(),
                         rand_quat_part(), rand_quat_part(), rand_quat_part());
            if (pending_poses.size() > 8)
                wait (pending_poses.size() <= 8);
        end
        wait (pending_poses.size() == 0 && !i_in_valid);
        wait (expected_looks.size() == 0);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
src/cplv_pkg.sv
src/camera_pose_look_vectors.sv
bench/camera_pose_look_vectors_tb.sv
